@@ hdl/ltwa_pkg.sv @@
`timescale 1ns / 1ps
package ltwa_pkg;
  localparam logic [2:0] FUNC_TICK    = 3'd0;
  localparam logic [2:0] FUNC_UPDATE  = 3'd1;
  localparam logic [2:0] FUNC_LOOKUP  = 3'd2;
  localparam logic [2:0] FUNC_RESERVE = 3'd3;
  localparam logic [2:0] FUNC_LIST    = 3'd4;

  localparam logic CFG_DEFAULT_TTL = 1'b0;
  localparam logic CFG_PLACE_TTL   = 1'b1;

  localparam logic [4:0] LIST_CAP = 5'd16;

  typedef struct packed {
    logic [2:0]  func;
    logic [47:0] mac;
    logic [31:0] ip;
    logic [31:0] lease_seconds;
    logic [4:0]  max_count;
  } cmd_t;

  typedef struct packed {
    logic        hit;
    logic [3:0]  slot;
    logic [47:0] mac_out;
    logic [31:0] ip_out;
    logic [32:0] expiry_out;
    logic        last;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_VICTIM,
    ST_WRITE,
    ST_LIST
  } state_t;
endpackage

@@ hdl/lease_table_with_aging.sv @@
`timescale 1ns / 1ps
// Lease table: ENTRIES slots keyed by MAC, aged by one-second tick items.
// Tick never raises busy. Update and reserve hold busy for a match walk and,
// on a miss, a victim walk and a write; lookup for the match walk; list for a
// slot walk. One item at a time; the last result strobe follows the last busy
// cycle (list strobes earlier entries while busy); the receiver cannot stall.
// Synchronous reset clears valid bits, time and loads default TTLs.
module lease_table_with_aging #(
  parameter int ENTRIES = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  ltwa_pkg::cmd_t    cmd,
  output logic              busy,
  output logic              done,
  output ltwa_pkg::result_t result,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_data
);
  import ltwa_pkg::*;

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IW:0] LAST_IDX = (IW + 1)'(ENTRIES - 1);
  localparam logic [IW:0] IDX_ONE = (IW + 1)'(1);
  // Result with every field zero except the last marker.
  localparam result_t EMPTY_LAST = {{($bits(result_t) - 1){1'b0}}, 1'b1};

  state_t state, state_next;
  logic done_next;
  cmd_t cur;
  logic [ENTRIES-1:0] valid;
  logic [47:0] mac_mem [ENTRIES];
  logic [31:0] ip_mem  [ENTRIES];
  logic [32:0] exp_mem [ENTRIES];
  logic [31:0] now;
  logic [31:0] def_ttl, plc_ttl;
  logic [IW:0] idx;           // walk pointer
  logic [IW-1:0] best;        // victim candidate
  logic [32:0] best_exp;
  logic        found_free;
  logic [4:0]  emitted, limit;
  logic [32:0] new_exp;
  result_t     pend;          // live entry held until the next one shows up

  // Shared compare unit operands for the current slot.
  logic [IW-1:0] ix;
  logic v, live, mac_eq;
  logic match, free_here, list_end;
  assign ix        = idx[IW-1:0];
  assign v         = valid[ix];
  assign live      = v && (exp_mem[ix] > {1'b0, now});
  assign mac_eq    = (mac_mem[ix] == cur.mac);
  // Match search; lookup demands a live entry.
  assign match     = (cur.func == FUNC_LOOKUP ? live : v) && mac_eq;
  assign free_here = !v || (exp_mem[ix] <= {1'b0, now});
  assign list_end  = (emitted == limit) || (idx > LAST_IDX);

  always_comb begin
    logic [31:0] ttl;
    if (cur.func == FUNC_RESERVE) ttl = plc_ttl;
    else if (cur.lease_seconds != 32'd0) ttl = cur.lease_seconds;
    else ttl = def_ttl;
    new_exp = {1'b0, now} + {1'b0, ttl};
  end

  assign busy = (state != ST_IDLE);

  function automatic logic [3:0] slot4(input logic [IW-1:0] s);
    logic [IW+3:0] w;
    w = {4'd0, s};
    return w[3:0];
  endfunction

  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          case (cmd.func)
            FUNC_UPDATE, FUNC_LOOKUP, FUNC_RESERVE: state_next = ST_SCAN;
            FUNC_LIST: state_next = ST_LIST;
            default: state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCAN: begin
        if (match || (idx == LAST_IDX && cur.func == FUNC_LOOKUP)) begin
          state_next = ST_IDLE;
          done_next  = 1'b1;
        end else if (idx == LAST_IDX) begin
          state_next = ST_VICTIM;
        end
      end
      ST_VICTIM: begin
        if (idx == LAST_IDX || (!found_free && free_here)) state_next = ST_WRITE;
      end
      ST_WRITE: begin
        state_next = ST_IDLE;
        done_next  = 1'b1;
      end
      ST_LIST: begin
        if (list_end) begin
          state_next = ST_IDLE;
          done_next  = 1'b1;
        end else if (live && emitted != 5'd0) begin
          done_next = 1'b1;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= '0;
      now     <= '0;
      def_ttl <= 32'd3600;
      plc_ttl <= 32'd120;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_DEFAULT_TTL) def_ttl <= cfg_data;
        else plc_ttl <= cfg_data;
      end
      case (state)
        ST_IDLE: begin
          if (start) begin
            cur <= cmd;
            idx <= '0;
            emitted <= '0;
            limit <= (cmd.max_count > LIST_CAP) ? LIST_CAP : cmd.max_count;
            found_free <= 1'b0;
            best <= '0;
            best_exp <= '1;
            // Advance time, holding at the top value.
            if (cmd.func == FUNC_TICK && now != '1) now <= now + 32'd1;
          end
        end
        ST_SCAN: begin
          if (match) begin
            result.hit <= 1'b1;
            result.slot <= slot4(ix);
            result.mac_out <= '0;
            result.last <= 1'b1;
            if (cur.func == FUNC_UPDATE) begin
              ip_mem[ix]  <= cur.ip;
              exp_mem[ix] <= new_exp;
              result.ip_out <= cur.ip;
              result.expiry_out <= new_exp;
            end else begin
              result.ip_out <= ip_mem[ix];
              result.expiry_out <= exp_mem[ix];
            end
          end else if (idx == LAST_IDX) begin
            if (cur.func == FUNC_LOOKUP) result <= EMPTY_LAST;
            else idx <= '0;
          end else idx <= idx + IDX_ONE;
        end
        ST_VICTIM: begin
          // First free/expired slot, else smallest expiry (lowest index).
          if (!found_free) begin
            if (free_here) begin
              found_free <= 1'b1;
              best <= ix;
            end else if (exp_mem[ix] < best_exp) begin
              best <= ix;
              best_exp <= exp_mem[ix];
            end
          end
          if (!(idx == LAST_IDX || (!found_free && free_here))) idx <= idx + IDX_ONE;
        end
        ST_WRITE: begin
          valid[best]   <= 1'b1;
          mac_mem[best] <= cur.mac;
          ip_mem[best]  <= (cur.func == FUNC_UPDATE) ? cur.ip : 32'd0;
          exp_mem[best] <= new_exp;
          result.hit <= 1'b0;
          result.slot <= slot4(best);
          result.mac_out <= '0;
          result.ip_out <= (cur.func == FUNC_UPDATE) ? cur.ip : 32'd0;
          result.expiry_out <= new_exp;
          result.last <= 1'b1;
        end
        ST_LIST: begin
          if (list_end) begin
            // Flush the held entry as the final result, or report an empty list.
            if (emitted == 5'd0) result <= EMPTY_LAST;
            else result <= {pend[$bits(result_t)-1:1], 1'b1};
          end else begin
            if (live) begin
              // Release the previously held entry; hold this one.
              if (emitted != 5'd0) result <= pend;
              pend <= {1'b1, slot4(ix), mac_mem[ix], ip_mem[ix], exp_mem[ix], 1'b0};
              emitted <= emitted + 5'd1;
            end
            idx <= idx + IDX_ONE;
          end
        end
        default: ;
      endcase
    end
  end

  a_done_idle_cmd: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (cmd.func == FUNC_TICK)) |=> !done)
    else $error("tick produced result");
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    (done && result.last && state != ST_LIST) |-> !busy)
    else $error("last result while still busy");
  a_hit_nonlist: assert property (@(posedge clk) disable iff (rst)
    (done && !result.hit) |-> (result.mac_out == '0))
    else $error("mac on miss");
endmodule
